/* rtl/cwr_pkg.sv */
package cwr_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // fixed field widths
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;

  // attribute after reset
  localparam logic [7:0] COLOUR_RESET = 8'h07;
  localparam logic [7:0] BLANK_CHAR   = 8'h00;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;

  // control bytes and printable range
  localparam logic [7:0] KEY_BACKSPACE = 8'h08;
  localparam logic [7:0] KEY_TAB       = 8'h09;
  localparam logic [7:0] KEY_NEWLINE   = 8'h0A;
  localparam logic [7:0] PRINT_LOW     = 8'h20;
  localparam logic [7:0] PRINT_HIGH    = 8'h7E;

  typedef enum logic [1:0] {
    FN_PUT    = 2'd0,
    FN_PUT_AT = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_READ   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_PUT,
    ST_RDWAIT,
    ST_SCROLL,
    ST_SCRLAST,
    ST_FILL
  } state_e;

endpackage

/* rtl/text_console_writer_core.sv */
// Text console writer: a COLUMNS x ROWS store of 16-bit cells (character in the
// low byte, attribute in the high byte) held in one synchronous RAM, plus a
// cursor. A request is taken on a clock edge with start_i high and busy_o low;
// exactly one result follows, shown for a single cycle with done_o high, and
// the receiver cannot hold it off, so it must capture it on that edge. After
// reset the block sweeps the RAM to blank cells with attribute 0x07, one cell a
// cycle, and keeps busy_o high until the last cell is written.
// A put, a newline, a backspace, an ignored byte or a positioned write is done in
// the EXEC state; a cell read waits in RDWAIT for the registered RAM read; a
// clear screen sweeps every cell in FILL, and a put or newline that runs off
// the last row adds a scroll through SCROLL, SCRLAST and FILL, one cell moved
// per cycle through the single RAM port pair. A tab is two puts, the second in
// the PUT state, and may add a scroll. The attribute register
// takes writes at any time on the cfg channel and must only change while idle.
module text_console_writer_core #(
  parameter int COLUMNS = cwr_pkg::COLUMNS_DEF,
  parameter int ROWS    = cwr_pkg::ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command channel
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   func_i,
  input  logic [7:0]                   ch_i,
  input  logic [6:0]                   col_i,
  input  logic [4:0]                   line_i,
  // result
  output logic                         done_o,
  output logic [cwr_pkg::CURSOR_W-1:0] cursor_position_o,
  output logic [7:0]                   read_char_o,
  output logic [7:0]                   read_attr_o,
  // attribute register write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [7:0]                   cfg_data_i
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  // text colour: background in the high nibble, foreground in the low
  logic [7:0] colour_q, colour_d;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [cwr_pkg::CELL_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [cwr_pkg::CELL_W-1:0] mem_rdata;
  logic [AW-1:0]              cursor;

  // the register is always ready; a write simply lands
  assign cfg_ready_o = 1'b1;

  always_comb begin
    colour_d = colour_q;
    if (cfg_valid_i && cfg_ready_o) begin
      colour_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_q <= cwr_pkg::COLOUR_RESET;
    end else begin
      colour_q <= colour_d;
    end
  end

  // sequencer: decodes requests, moves the cursor, runs scroll and fill sweeps
  cwr_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .func_i      (func_i),
    .ch_i        (ch_i),
    .col_i       (col_i),
    .line_i      (line_i),
    .colour_i    (colour_q),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .cursor_o    (cursor),
    .read_char_o (read_char_o),
    .read_attr_o (read_attr_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // cell store, one write and one registered read per cycle
  cwr_cell_mem #(
    .DEPTH (CELLS)
  ) u_cell_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // cursor index is always below the cell count, so this only widens or trims
  assign cursor_position_o = cwr_pkg::CURSOR_W'(cursor);

  // a request taken always makes the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but block not busy");

  // a result is only shown once the sequencer is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // one result per request: strobes never come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

  // cursor never points past the last cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cursor) < CELLS)
    else $error("cursor out of range");

endmodule

/* rtl/cwr_cell_mem.sv */
module cwr_cell_mem #(
  parameter int DEPTH = cwr_pkg::COLUMNS_DEF * cwr_pkg::ROWS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [cwr_pkg::CELL_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [cwr_pkg::CELL_W-1:0] rdata_o
);

  logic [cwr_pkg::CELL_W-1:0] mem [DEPTH];
  logic [cwr_pkg::CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cwr_ctrl.sv */
module cwr_ctrl #(
  parameter int COLUMNS = cwr_pkg::COLUMNS_DEF,
  parameter int ROWS    = cwr_pkg::ROWS_DEF,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int AW     = $clog2(CELLS)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [1:0]                 func_i,
  input  logic [7:0]                 ch_i,
  input  logic [6:0]                 col_i,
  input  logic [4:0]                 line_i,
  input  logic [7:0]                 colour_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [AW-1:0]              cursor_o,
  output logic [7:0]                 read_char_o,
  output logic [7:0]                 read_attr_o,
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_waddr_o,
  output logic [cwr_pkg::CELL_W-1:0] mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  logic [cwr_pkg::CELL_W-1:0] mem_rdata_i
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_ROW  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);

  cwr_pkg::state_e state_q, state_d;
  cwr_pkg::func_e  func_q, func_d;
  logic [7:0]      ch_q, ch_d;
  logic            inside_q, inside_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [AW-1:0]   dst_q, dst_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic            pend_q, pend_d;
  logic            more_q, more_d;
  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;
  logic [AW-1:0]   lin_q, lin_d;
  logic            done_q, done_d;
  logic [7:0]      rch_q, rch_d;
  logic [7:0]      rat_q, rat_d;

  logic            put_go;
  logic            put_again;
  logic [7:0]      put_ch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cwr_pkg::ST_INIT;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
      more_q  <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
      lin_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
      more_q  <= more_d;
      col_q   <= col_d;
      row_q   <= row_d;
      lin_q   <= lin_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    ch_q     <= ch_d;
    inside_q <= inside_d;
    addr_q   <= addr_d;
    dst_q    <= dst_d;
    rch_q    <= rch_d;
    rat_q    <= rat_d;
  end

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    ch_d        = ch_q;
    inside_d    = inside_q;
    addr_d      = addr_q;
    dst_d       = dst_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    more_d      = more_q;
    col_d       = col_q;
    row_d       = row_q;
    lin_d       = lin_q;
    done_d      = 1'b0;
    rch_d       = '0;
    rat_d       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = lin_q;
    mem_wdata_o = {colour_i, cwr_pkg::BLANK_CHAR};
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q;
    put_go      = 1'b0;
    put_again   = 1'b0;
    put_ch      = cwr_pkg::SPACE_CHAR;

    unique case (state_q)
      cwr_pkg::ST_INIT: begin
        // clearing pass after reset
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q;
        mem_wdata_o = {cwr_pkg::COLOUR_RESET, cwr_pkg::BLANK_CHAR};
        if (ptr_q == CELL_LAST) begin
          state_d = cwr_pkg::ST_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      cwr_pkg::ST_IDLE: begin
        if (start_i) begin
          func_d   = cwr_pkg::func_e'(func_i);
          ch_d     = ch_i;
          inside_d = ({2'b00, col_i} < 9'(COLUMNS)) && ({3'b000, line_i} < 8'(ROWS));
          addr_d   = AW'(line_i * AW'(COLUMNS) + col_i);
          state_d  = cwr_pkg::ST_EXEC;
        end
      end

      cwr_pkg::ST_EXEC: begin
        unique case (func_q)
          cwr_pkg::FN_PUT: begin
            priority if (ch_q >= cwr_pkg::PRINT_LOW && ch_q <= cwr_pkg::PRINT_HIGH) begin
              put_go = 1'b1;
              put_ch = ch_q;
            end else if (ch_q == cwr_pkg::KEY_NEWLINE) begin
              col_d = '0;
              if (row_q == ROW_LAST) begin
                state_d = cwr_pkg::ST_SCROLL;
                ptr_d   = ROW_STEP;
                pend_d  = 1'b0;
                more_d  = 1'b0;
                lin_d   = LAST_ROW;
              end else begin
                row_d   = row_q + 1'b1;
                lin_d   = lin_q - AW'(col_q) + ROW_STEP;
                done_d  = 1'b1;
                state_d = cwr_pkg::ST_IDLE;
              end
            end else if (ch_q == cwr_pkg::KEY_BACKSPACE) begin
              if (lin_q != '0) begin
                lin_d       = lin_q - 1'b1;
                mem_we_o    = 1'b1;
                mem_waddr_o = lin_q - 1'b1;
                if (col_q == '0) begin
                  col_d = COL_LAST;
                  row_d = row_q - 1'b1;
                end else begin
                  col_d = col_q - 1'b1;
                end
              end
              done_d  = 1'b1;
              state_d = cwr_pkg::ST_IDLE;
            end else if (ch_q == cwr_pkg::KEY_TAB) begin
              put_go    = 1'b1;
              put_again = 1'b1;
            end else begin
              done_d  = 1'b1;
              state_d = cwr_pkg::ST_IDLE;
            end
          end

          cwr_pkg::FN_PUT_AT: begin
            if (inside_q) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = addr_q;
              mem_wdata_o = {colour_i, ch_q};
            end
            done_d  = 1'b1;
            state_d = cwr_pkg::ST_IDLE;
          end

          cwr_pkg::FN_CLEAR: begin
            ptr_d   = '0;
            col_d   = '0;
            row_d   = '0;
            lin_d   = '0;
            more_d  = 1'b0;
            state_d = cwr_pkg::ST_FILL;
          end

          cwr_pkg::FN_READ: begin
            if (inside_q) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = addr_q;
              state_d     = cwr_pkg::ST_RDWAIT;
            end else begin
              done_d  = 1'b1;
              state_d = cwr_pkg::ST_IDLE;
            end
          end

          default: begin
            state_d = cwr_pkg::ST_IDLE;
          end
        endcase
      end

      cwr_pkg::ST_PUT: begin
        // second space of a tab
        more_d = 1'b0;
        put_go = 1'b1;
      end

      cwr_pkg::ST_RDWAIT: begin
        rch_d   = mem_rdata_i[7:0];
        rat_d   = mem_rdata_i[15:8];
        done_d  = 1'b1;
        state_d = cwr_pkg::ST_IDLE;
      end

      cwr_pkg::ST_SCROLL: begin
        // read one row ahead, write the cell fetched last cycle
        mem_re_o    = 1'b1;
        mem_raddr_o = ptr_q;
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = dst_q;
          mem_wdata_o = mem_rdata_i;
        end
        dst_d  = ptr_q - ROW_STEP;
        pend_d = 1'b1;
        if (ptr_q == CELL_LAST) begin
          state_d = cwr_pkg::ST_SCRLAST;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      cwr_pkg::ST_SCRLAST: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = dst_q;
        mem_wdata_o = mem_rdata_i;
        pend_d      = 1'b0;
        ptr_d       = LAST_ROW;
        state_d     = cwr_pkg::ST_FILL;
      end

      cwr_pkg::ST_FILL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q;
        if (ptr_q == CELL_LAST) begin
          if (func_q != cwr_pkg::FN_CLEAR && more_q) begin
            more_d  = 1'b0;
            state_d = cwr_pkg::ST_PUT;
          end else begin
            done_d  = 1'b1;
            state_d = cwr_pkg::ST_IDLE;
          end
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      default: begin
        state_d = cwr_pkg::ST_IDLE;
      end
    endcase

    // store at the cursor, advance, scroll when running off the end
    if (put_go) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = lin_q;
      mem_wdata_o = {colour_i, put_ch};
      if (col_q == COL_LAST && row_q == ROW_LAST) begin
        col_d   = '0;
        lin_d   = LAST_ROW;
        ptr_d   = ROW_STEP;
        pend_d  = 1'b0;
        more_d  = put_again;
        state_d = cwr_pkg::ST_SCROLL;
      end else begin
        if (col_q == COL_LAST) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
        lin_d = lin_q + 1'b1;
        if (put_again) begin
          state_d = cwr_pkg::ST_PUT;
        end else begin
          done_d  = 1'b1;
          state_d = cwr_pkg::ST_IDLE;
        end
      end
    end
  end

  assign busy_o      = (state_q != cwr_pkg::ST_IDLE);
  assign done_o      = done_q;
  assign cursor_o    = lin_q;
  assign read_char_o = rch_q;
  assign read_attr_o = rat_q;

endmodule
